@@ sv/jtv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and fixed constants for the jittered target velocity block.
// No dependencies; every file but jtv_front refers to this package by scoped names.
package jtv_pkg;

  // Inverse CORDIC gain in Q20 and its width.
  localparam int          GAIN_BITS    = 20;
  localparam logic [19:0] INV_GAIN_Q20 = 20'd636751;

  // Guard bits carried through the rotation pass.
  localparam int ROT_GUARD = 8;

  // Vectoring pre-scale target: offsets are lifted to this many bits.
  localparam int VEC_SCALE_BITS = 34;

  // Limit on each operand of the proportional product.
  localparam logic signed [63:0] PRE_LIMIT = 64'sd2147483647;

  // Configuration register indexes.
  localparam logic [2:0] CFG_TARGET_X         = 3'd0;
  localparam logic [2:0] CFG_TARGET_Y         = 3'd1;
  localparam logic [2:0] CFG_TARGET_SPREAD    = 3'd2;
  localparam logic [2:0] CFG_BASE_MAGNITUDE   = 3'd3;
  localparam logic [2:0] CFG_MAGNITUDE_SPREAD = 3'd4;
  localparam logic [2:0] CFG_PROPORTIONAL     = 3'd5;

  // Per-word side flags that ride along the pipeline.
  typedef struct packed {
    logic flip;   // offset was negated before vectoring
    logic zero;   // offset was exactly zero
  } jtv_flags_t;

endpackage

@@ sv/jittered_target_velocity.sv @@
`timescale 1ns / 1ps
// Top level of the jittered target velocity block: config registers and pipeline.
// Depends on jtv_pkg, jtv_front, jtv_vec, jtv_scale and jtv_rot.
//
// Each input word carries a source point and three random fractions; the block
// returns one velocity word aimed from the source at the configured target,
// with the target jittered by +-target_spread per axis and the speed jittered
// by +-magnitude_spread (scaled by distance in proportional mode). The work is
// a fully pipelined datapath: two jitter stages, a half-plane fold register, a
// vectoring CORDIC of CORDIC_STAGES stages plus a two-stage split gain multiply,
// four magnitude scaling stages, and a rotation CORDIC of CORDIC_STAGES stages
// ending in the output register. A new word is taken every cycle while in_ready
// is high. The whole pipeline advances together, so in_ready drops only while
// a finished word sits in the output register and out_ready is low. Write
// configuration only while no word is in flight.
module jittered_target_velocity #(
  parameter int COORD_WIDTH   = 24,
  parameter int FRAC_BITS     = 8,
  parameter int RAND_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_source_x,
  input  logic signed [COORD_WIDTH-1:0] in_source_y,
  input  logic [RAND_BITS-1:0]          in_rand_jitter_x,
  input  logic [RAND_BITS-1:0]          in_rand_jitter_y,
  input  logic [RAND_BITS-1:0]          in_rand_speed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_velocity_x,
  output logic signed [COORD_WIDTH-1:0] out_velocity_y,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata
);

  localparam int W = COORD_WIDTH;
  localparam int N = CORDIC_STAGES;

  // Configuration registers.
  logic signed [W-1:0] target_x_r, target_y_r, base_magnitude_r;
  logic [W-2:0]        target_spread_r, magnitude_spread_r;
  logic                proportional_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r          <= '0;
      target_y_r          <= '0;
      target_spread_r     <= '0;
      base_magnitude_r    <= '0;
      magnitude_spread_r  <= '0;
      proportional_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jtv_pkg::CFG_TARGET_X:         target_x_r          <= cfg_wdata;
        jtv_pkg::CFG_TARGET_Y:         target_y_r          <= cfg_wdata;
        jtv_pkg::CFG_TARGET_SPREAD:    target_spread_r     <= cfg_wdata[W-2:0];
        jtv_pkg::CFG_BASE_MAGNITUDE:   base_magnitude_r    <= cfg_wdata;
        jtv_pkg::CFG_MAGNITUDE_SPREAD: magnitude_spread_r  <= cfg_wdata[W-2:0];
        jtv_pkg::CFG_PROPORTIONAL:     proportional_mode_r <= cfg_wdata[0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Advance every stage unless the output word is held.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic                f_valid;
  logic signed [W+1:0] f_dx, f_dy;
  logic signed [W:0]   f_mag;

  jtv_front #(.W(W), .R(RAND_BITS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .in_valid         (in_valid),
    .source_x         (in_source_x),
    .source_y         (in_source_y),
    .rand_jx          (in_rand_jitter_x),
    .rand_jy          (in_rand_jitter_y),
    .rand_sp          (in_rand_speed),
    .target_x         (target_x_r),
    .target_y         (target_y_r),
    .target_spread    (target_spread_r),
    .base_magnitude   (base_magnitude_r),
    .magnitude_spread (magnitude_spread_r),
    .out_valid        (f_valid),
    .dx               (f_dx),
    .dy               (f_dy),
    .mag              (f_mag)
  );

  logic                v_valid;
  logic [W+3:0]        v_dist;
  logic signed [W:0]   v_mag;
  jtv_pkg::jtv_flags_t v_flags;
  logic [N-1:0]        v_dirs;

  jtv_vec #(.W(W), .N(N)) u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (f_valid),
    .dx        (f_dx),
    .dy        (f_dy),
    .mag_in    (f_mag),
    .out_valid (v_valid),
    .distance  (v_dist),
    .mag_out   (v_mag),
    .flags_out (v_flags),
    .dirs_out  (v_dirs)
  );

  logic                 s_valid;
  logic signed [W+17:0] s_x0;
  logic signed [W:0]    s_mag;
  jtv_pkg::jtv_flags_t  s_flags;
  logic [N-1:0]         s_dirs;

  jtv_scale #(.W(W), .F(FRAC_BITS), .N(N)) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v_valid),
    .distance  (v_dist),
    .mag_in    (v_mag),
    .flags_in  (v_flags),
    .dirs_in   (v_dirs),
    .prop      (proportional_mode_r),
    .out_valid (s_valid),
    .x0        (s_x0),
    .mag_out   (s_mag),
    .flags_out (s_flags),
    .dirs_out  (s_dirs)
  );

  jtv_rot #(.W(W), .N(N)) u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s_valid),
    .x0        (s_x0),
    .mag_in    (s_mag),
    .flags_in  (s_flags),
    .dirs_in   (s_dirs),
    .prop      (proportional_mode_r),
    .out_valid (out_valid),
    .vel_x     (out_velocity_x),
    .vel_y     (out_velocity_y)
  );

`ifndef SYNTHESIS
  // With zero magnitude and no magnitude jitter every word comes out still.
  a_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (base_magnitude_r == '0) && (magnitude_spread_r == '0)
      && $stable(base_magnitude_r) && $stable(magnitude_spread_r)
      && !cfg_we && !$past(cfg_we)
    |-> (out_velocity_x == '0) && (out_velocity_y == '0))
    else $error("nonzero velocity with zero magnitude");
`endif

endmodule

@@ sv/jtv_front.sv @@
`timescale 1ns / 1ps
// Front end: target and magnitude jitter products, then offset and magnitude sums.
// Does not depend on jtv_pkg or on any other file.
module jtv_front #(
  parameter int W = 24,
  parameter int R = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  logic signed [W-1:0] source_x,
  input  logic signed [W-1:0] source_y,
  input  logic [R-1:0]        rand_jx,
  input  logic [R-1:0]        rand_jy,
  input  logic [R-1:0]        rand_sp,
  input  logic signed [W-1:0] target_x,
  input  logic signed [W-1:0] target_y,
  input  logic [W-2:0]        target_spread,
  input  logic signed [W-1:0] base_magnitude,
  input  logic [W-2:0]        magnitude_spread,
  output logic                out_valid,
  output logic signed [W+1:0] dx,
  output logic signed [W+1:0] dy,
  output logic signed [W:0]   mag
);

  localparam int DW = W + 2;
  localparam int PW = R + W;

  logic                v1_r, v2_r;
  logic signed [W-1:0] sx_r, sy_r;
  logic [PW-1:0]       jx_r, jy_r, jm_r;
  logic [PW-1:0]       jx_nxt, jy_nxt, jm_nxt;
  logic [W-1:0]        jx, jy, jm;
  logic signed [DW-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [W:0]    mag_r, mag_nxt;

  // Stage 1: r * 2s, one multiplier per fraction.
  always_comb begin
    jx_nxt = PW'(rand_jx) * PW'({target_spread, 1'b0});
    jy_nxt = PW'(rand_jy) * PW'({target_spread, 1'b0});
    jm_nxt = PW'(rand_sp) * PW'({magnitude_spread, 1'b0});
  end

  // Stage 2: drop the fraction bits, form offsets and magnitude.
  always_comb begin
    jx = jx_r[PW-1:R];
    jy = jy_r[PW-1:R];
    jm = jm_r[PW-1:R];
    dx_nxt = {{2{target_x[W-1]}}, target_x} - {{2{sx_r[W-1]}}, sx_r}
           - {3'b000, target_spread} + {2'b00, jx};
    dy_nxt = {{2{target_y[W-1]}}, target_y} - {{2{sy_r[W-1]}}, sy_r}
           - {3'b000, target_spread} + {2'b00, jy};
    mag_nxt = {base_magnitude[W-1], base_magnitude} - {2'b00, magnitude_spread}
            + {1'b0, jm};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r  <= source_x;
      sy_r  <= source_y;
      jx_r  <= jx_nxt;
      jy_r  <= jy_nxt;
      jm_r  <= jm_nxt;
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      mag_r <= mag_nxt;
    end
  end

  assign out_valid = v2_r;
  assign dx        = dx_r;
  assign dy        = dy_r;
  assign mag       = mag_r;

endmodule

@@ sv/jtv_vec.sv @@
`timescale 1ns / 1ps
// Vectoring CORDIC pipeline: offset angle directions and distance.
// Depends on jtv_pkg for the gain constant and the side flag struct.
module jtv_vec #(
  parameter int W = 24,
  parameter int N = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic signed [W+1:0]   dx,
  input  logic signed [W+1:0]   dy,
  input  logic signed [W:0]     mag_in,
  output logic                  out_valid,
  output logic [W+3:0]          distance,
  output logic signed [W:0]     mag_out,
  output jtv_pkg::jtv_flags_t   flags_out,
  output logic [N-1:0]          dirs_out
);

  localparam int DW = W + 2;
  localparam int VG = jtv_pkg::VEC_SCALE_BITS - W;
  localparam int XW = DW + VG + 2;
  localparam int GB = jtv_pkg::GAIN_BITS;
  localparam int LO_BITS = XW / 2;
  localparam int HI_BITS = XW - LO_BITS;
  localparam int SW = XW + GB;

  logic                 v_r     [0:N];
  logic signed [XW-1:0] x_r     [0:N];
  logic signed [XW-1:0] y_r     [0:N];
  logic [N-1:0]         dirs_r  [0:N];
  jtv_pkg::jtv_flags_t  flags_r [0:N];
  logic signed [W:0]    mag_r   [0:N];

  logic signed [DW-1:0] ax, ay;
  jtv_pkg::jtv_flags_t  flags_nxt;

  // Fold the left half plane onto the right one.
  always_comb begin
    flags_nxt.flip = dx[DW-1];
    flags_nxt.zero = (dx == '0) && (dy == '0);
    ax = dx[DW-1] ? -dx : dx;
    ay = dx[DW-1] ? -dy : dy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r[0]     <= {{2{ax[DW-1]}}, ax, {VG{1'b0}}};
      y_r[0]     <= {{2{ay[DW-1]}}, ay, {VG{1'b0}}};
      dirs_r[0]  <= '0;
      flags_r[0] <= flags_nxt;
      mag_r[0]   <= mag_in;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                 d;
    logic signed [XW-1:0] x_nxt, y_nxt;
    logic [N-1:0]         dirs_nxt;

    // Turn toward the x axis.
    always_comb begin
      d        = !y_r[i][XW-1];
      dirs_nxt = dirs_r[i];
      dirs_nxt[i] = d;
      if (d) begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
      end else begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i+1]     <= x_nxt;
        y_r[i+1]     <= y_nxt;
        dirs_r[i+1]  <= dirs_nxt;
        flags_r[i+1] <= flags_r[i];
        mag_r[i+1]   <= mag_r[i];
      end
    end
  end

  // Gain correction: split x into two halves, multiply, then recombine.
  logic                         vm_r, vd_r;
  logic [HI_BITS+GB-1:0]        ph_r;
  logic [LO_BITS+GB-1:0]        pl_r;
  logic [N-1:0]                 dirs_m_r, dirs_d_r;
  jtv_pkg::jtv_flags_t          flags_m_r, flags_d_r;
  logic signed [W:0]            mag_m_r, mag_d_r;
  logic [W+3:0]                 dist_r;
  logic [SW-1:0]                sum;

  always_comb begin
    sum = (SW'(ph_r) << LO_BITS) + SW'(pl_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (adv) begin
      vm_r <= v_r[N];
      vd_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_r      <= (HI_BITS+GB)'(x_r[N][XW-1:LO_BITS])
                   * (HI_BITS+GB)'(jtv_pkg::INV_GAIN_Q20);
      pl_r      <= (LO_BITS+GB)'(x_r[N][LO_BITS-1:0])
                   * (LO_BITS+GB)'(jtv_pkg::INV_GAIN_Q20);
      dirs_m_r  <= dirs_r[N];
      flags_m_r <= flags_r[N];
      mag_m_r   <= mag_r[N];
      dist_r    <= (W+4)'(sum >> (GB + VG));
      dirs_d_r  <= dirs_m_r;
      flags_d_r <= flags_m_r;
      mag_d_r   <= mag_m_r;
    end
  end

  assign out_valid = vd_r;
  assign distance  = dist_r;
  assign mag_out   = mag_d_r;
  assign flags_out = flags_d_r;
  assign dirs_out  = dirs_d_r;

`ifndef SYNTHESIS
  // x only grows through the vectoring stages from a nonnegative start.
  a_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[N] |-> !x_r[N][XW-1])
    else $error("vectoring x went negative");

  // A zero offset enters the stages as the origin.
  a_zero_origin: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && flags_r[0].zero |-> (x_r[0] == '0) && (y_r[0] == '0))
    else $error("zero flag set on a nonzero offset");
`endif

endmodule

@@ sv/jtv_scale.sv @@
`timescale 1ns / 1ps
// Magnitude scaling: proportional product, clamp, and rotation start value.
// Depends on jtv_pkg for limits, gain and the side flag struct.
module jtv_scale #(
  parameter int W = 24,
  parameter int F = 8,
  parameter int N = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [W+3:0]          distance,
  input  logic signed [W:0]     mag_in,
  input  jtv_pkg::jtv_flags_t   flags_in,
  input  logic [N-1:0]          dirs_in,
  input  logic                  prop,
  output logic                  out_valid,
  output logic signed [W+17:0]  x0,
  output logic signed [W:0]     mag_out,
  output jtv_pkg::jtv_flags_t   flags_out,
  output logic [N-1:0]          dirs_out
);

  localparam int MW = W + 8;
  localparam int RW = W + 18;
  localparam int SHIFT = jtv_pkg::GAIN_BITS - jtv_pkg::ROT_GUARD;
  localparam logic signed [63:0] MAG_LIM = (64'sd1 <<< (W + 7)) - 64'sd1;

  logic                v_r     [1:4];
  logic signed [W:0]   mag_r   [1:4];
  jtv_pkg::jtv_flags_t flags_r [1:4];
  logic [N-1:0]        dirs_r  [1:4];

  logic signed [31:0]  a_r, b_r, a_nxt, b_nxt;
  logic signed [63:0]  p_r;
  logic signed [MW-1:0] m_r, m_nxt;
  logic signed [RW-1:0] x0_r;
  logic signed [63:0]  mag64, dist64, pm, x0_full;

  // Clamp both operands of the proportional product.
  always_comb begin
    mag64  = 64'(mag_in);
    dist64 = signed'(64'(distance));
    if (mag64 > jtv_pkg::PRE_LIMIT)       a_nxt = jtv_pkg::PRE_LIMIT[31:0];
    else if (mag64 < -jtv_pkg::PRE_LIMIT) a_nxt = 32'(-jtv_pkg::PRE_LIMIT);
    else                                  a_nxt = mag64[31:0];
    if (dist64 > jtv_pkg::PRE_LIMIT) b_nxt = jtv_pkg::PRE_LIMIT[31:0];
    else                             b_nxt = dist64[31:0];
  end

  // Select the scaled magnitude and clamp it for the rotation pass.
  always_comb begin
    pm = prop ? (p_r >>> F) : 64'(mag_r[2]);
    if (pm > MAG_LIM)       m_nxt = MW'(MAG_LIM);
    else if (pm < -MAG_LIM) m_nxt = MW'(-MAG_LIM);
    else                    m_nxt = MW'(pm);
  end

  always_comb begin
    x0_full = (64'(m_r) * 64'(signed'({1'b0, jtv_pkg::INV_GAIN_Q20}))) >>> SHIFT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 4; k++) v_r[k] <= 1'b0;
    end else if (adv) begin
      v_r[1] <= in_valid;
      for (int k = 1; k < 4; k++) v_r[k+1] <= v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r[1]   <= mag_in;
      flags_r[1] <= flags_in;
      dirs_r[1]  <= dirs_in;
      for (int k = 1; k < 4; k++) begin
        mag_r[k+1]   <= mag_r[k];
        flags_r[k+1] <= flags_r[k];
        dirs_r[k+1]  <= dirs_r[k];
      end
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      p_r  <= 64'(a_r) * 64'(b_r);
      m_r  <= m_nxt;
      x0_r <= RW'(x0_full);
    end
  end

  assign out_valid = v_r[4];
  assign x0        = x0_r;
  assign mag_out   = mag_r[4];
  assign flags_out = flags_r[4];
  assign dirs_out  = dirs_r[4];

endmodule

@@ sv/jtv_rot.sv @@
`timescale 1ns / 1ps
// Rotation CORDIC pipeline replaying the vectoring directions, then round and saturate.
// Depends on jtv_pkg for the guard width and the side flag struct.
module jtv_rot #(
  parameter int W = 24,
  parameter int N = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic signed [W+17:0]  x0,
  input  logic signed [W:0]     mag_in,
  input  jtv_pkg::jtv_flags_t   flags_in,
  input  logic [N-1:0]          dirs_in,
  input  logic                  prop,
  output logic                  out_valid,
  output logic signed [W-1:0]   vel_x,
  output logic signed [W-1:0]   vel_y
);

  localparam int RW = W + 18;
  localparam int GD = jtv_pkg::ROT_GUARD;
  localparam logic signed [RW:0] HI = (RW+1)'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [RW:0] LO = -HI - (RW+1)'(1);
  localparam logic signed [RW:0] HALF = (RW+1)'(1) <<< (GD - 1);

  logic                 v_r     [1:N];
  logic signed [RW-1:0] x_r     [1:N];
  logic signed [RW-1:0] y_r     [1:N];
  logic [N-1:0]         dirs_r  [1:N];
  jtv_pkg::jtv_flags_t  flags_r [1:N];
  logic signed [W:0]    mag_r   [1:N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic                 vi;
    logic signed [RW-1:0] xi, yi, x_nxt, y_nxt;
    logic [N-1:0]         di;
    jtv_pkg::jtv_flags_t  fi;
    logic signed [W:0]    mi;

    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign xi = x0;
      assign yi = '0;
      assign di = dirs_in;
      assign fi = flags_in;
      assign mi = mag_in;
    end else begin : g_next
      assign vi = v_r[i];
      assign xi = x_r[i];
      assign yi = y_r[i];
      assign di = dirs_r[i];
      assign fi = flags_r[i];
      assign mi = mag_r[i];
    end

    // Replay the recorded turn in the opposite sense.
    always_comb begin
      if (di[i]) begin
        x_nxt = xi - (yi >>> i);
        y_nxt = yi + (xi >>> i);
      end else begin
        x_nxt = xi + (yi >>> i);
        y_nxt = yi - (xi >>> i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i+1]     <= x_nxt;
        y_r[i+1]     <= y_nxt;
        dirs_r[i+1]  <= di;
        flags_r[i+1] <= fi;
        mag_r[i+1]   <= mi;
      end
    end
  end

  logic signed [RW:0]  xe, ye, xr, yr, me;
  logic signed [W-1:0] vx_nxt, vy_nxt, mag_sat;
  logic signed [W-1:0] xs, ys;
  logic                out_valid_r;
  logic signed [W-1:0] vx_r, vy_r;

  // Undo the half turn, round guard bits half up, saturate, special-case a zero offset.
  always_comb begin
    xe = flags_r[N].flip ? -(RW+1)'(x_r[N]) : (RW+1)'(x_r[N]);
    ye = flags_r[N].flip ? -(RW+1)'(y_r[N]) : (RW+1)'(y_r[N]);
    xr = (xe + HALF) >>> GD;
    yr = (ye + HALF) >>> GD;
    me = (RW+1)'(mag_r[N]);
    if (xr > HI)      xs = HI[W-1:0];
    else if (xr < LO) xs = LO[W-1:0];
    else              xs = xr[W-1:0];
    if (yr > HI)      ys = HI[W-1:0];
    else if (yr < LO) ys = LO[W-1:0];
    else              ys = yr[W-1:0];
    if (me > HI)      mag_sat = HI[W-1:0];
    else if (me < LO) mag_sat = LO[W-1:0];
    else              mag_sat = me[W-1:0];
    if (flags_r[N].zero) begin
      vx_nxt = prop ? '0 : mag_sat;
      vy_nxt = '0;
    end else begin
      vx_nxt = xs;
      vy_nxt = ys;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign vel_x     = vx_r;
  assign vel_y     = vy_r;

`ifndef SYNTHESIS
  // A zero offset always leaves with no y component.
  a_zero_y: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v_r[N] && flags_r[N].zero |=> vel_y == '0)
    else $error("zero offset gave a nonzero y component");

  // The output stage comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid right after reset");
`endif

endmodule

@@ verif/tb_jittered_target_velocity.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for jittered_target_velocity: drives source words,
// predicts each velocity word in-bench, and compares field by field.
// Depends on jtv_pkg and the jittered_target_velocity RTL.
module tb_jittered_target_velocity;

  localparam int CW        = 24;
  localparam int RB        = 16;
  localparam int FRAC      = 8;
  localparam int STAGES    = 16;
  localparam int VEC_GUARD = jtv_pkg::VEC_SCALE_BITS - CW;
  localparam int LATENCY   = 2 * STAGES + 10;
  localparam int CYCLE_LIMIT = 600000;
  localparam longint OUT_MAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint MAG_MAX = (64'sd1 <<< (CW + 7)) - 1;

  typedef struct {
    logic signed [CW-1:0] src_x;
    logic signed [CW-1:0] src_y;
    logic [RB-1:0]        jit_x;
    logic [RB-1:0]        jit_y;
    logic [RB-1:0]        speed;
  } emission_t;

  typedef struct {
    logic signed [CW-1:0] vel_x;
    logic signed [CW-1:0] vel_y;
  } velocity_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [CW-1:0] in_source_x;
  logic signed [CW-1:0] in_source_y;
  logic [RB-1:0]        in_rand_jitter_x;
  logic [RB-1:0]        in_rand_jitter_y;
  logic [RB-1:0]        in_rand_speed;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [CW-1:0] out_velocity_x;
  logic signed [CW-1:0] out_velocity_y;
  logic                 cfg_we;
  logic [2:0]           cfg_index;
  logic [CW-1:0]        cfg_wdata;

  // Bench copy of the configuration registers.
  logic signed [CW-1:0] tgt_x;
  logic signed [CW-1:0] tgt_y;
  logic [CW-2:0]        tgt_spread;
  logic signed [CW-1:0] base_mag;
  logic [CW-2:0]        mag_spread;
  logic                 prop_mode;

  emission_t emission_q[$];     // words waiting to be sent
  velocity_t velocity_q[$];     // predicted velocities in flight
  int        fail_count = 0;
  int        cycle_count = 0;
  int        burst_left;
  int        gap_left;
  int        ready_run;

  jittered_target_velocity i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_source_x      (in_source_x),
    .in_source_y      (in_source_y),
    .in_rand_jitter_x (in_rand_jitter_x),
    .in_rand_jitter_y (in_rand_jitter_y),
    .in_rand_speed    (in_rand_speed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_velocity_x   (out_velocity_x),
    .out_velocity_y   (out_velocity_y),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Jitter term: floor(r * 2s / 2^RB).
  function automatic longint jitter_term(input logic [RB-1:0] r, input logic [CW-2:0] s);
    longint rr;
    longint ss;
    rr = r;
    ss = s;
    return (rr * ss * 2) >>> RB;
  endfunction

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic signed [CW-1:0] saturate(input longint v);
    if (v > OUT_MAX) return OUT_MAX[CW-1:0];
    if (v < -OUT_MAX - 1) return {1'b1, {(CW-1){1'b0}}};
    return v[CW-1:0];
  endfunction

  // Aim (magnitude, 0) at the jittered target with a vectoring pass and a
  // matching rotation pass, exactly as the block's fixed-point datapath does.
  function automatic velocity_t predict_velocity(input emission_t e);
    velocity_t  v;
    longint     dx, dy, mag, x, y, nx, distance;
    bit [STAGES-1:0] turn_cw;
    bit         flip;
    dx = longint'(tgt_x) - longint'(e.src_x) - longint'(tgt_spread)
         + jitter_term(e.jit_x, tgt_spread);
    dy = longint'(tgt_y) - longint'(e.src_y) - longint'(tgt_spread)
         + jitter_term(e.jit_y, tgt_spread);
    mag = longint'(base_mag) - longint'(mag_spread) + jitter_term(e.speed, mag_spread);
    if (dx == 0 && dy == 0) begin
      if (prop_mode) mag = 0;
      v.vel_x = saturate(mag);
      v.vel_y = '0;
      return v;
    end
    flip = dx < 0;
    if (flip) begin
      dx = -dx;
      dy = -dy;
    end
    x = dx <<< VEC_GUARD;
    y = dy <<< VEC_GUARD;
    for (int i = 0; i < STAGES; i++) begin
      turn_cw[i] = y >= 0;
      if (turn_cw[i]) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
      end
      x = nx;
    end
    distance = (x * longint'(jtv_pkg::INV_GAIN_Q20)) >>> (jtv_pkg::GAIN_BITS + VEC_GUARD);
    if (prop_mode)
      mag = (clip(mag, jtv_pkg::PRE_LIMIT) * clip(distance, jtv_pkg::PRE_LIMIT)) >>> FRAC;
    mag = clip(mag, MAG_MAX);
    // Replay the recorded turns backwards onto (mag, 0) with guard bits.
    x = (mag * longint'(jtv_pkg::INV_GAIN_Q20)) >>> (jtv_pkg::GAIN_BITS - jtv_pkg::ROT_GUARD);
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (turn_cw[i]) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    v.vel_x = saturate((x + (64'sd1 <<< (jtv_pkg::ROT_GUARD - 1))) >>> jtv_pkg::ROT_GUARD);
    v.vel_y = saturate((y + (64'sd1 <<< (jtv_pkg::ROT_GUARD - 1))) >>> jtv_pkg::ROT_GUARD);
    return v;
  endfunction

  // Driver: send queued words in bursts with random gaps; hold a word until taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid         <= 1'b0;
      in_source_x      <= '0;
      in_source_y      <= '0;
      in_rand_jitter_x <= '0;
      in_rand_jitter_y <= '0;
      in_rand_speed    <= '0;
      burst_left       <= 1;
      gap_left         <= 0;
    end else begin
      if (in_valid && in_ready)
        velocity_q.push_back(predict_velocity(emission_q.pop_front()));
      if (in_valid && !in_ready) begin
        // hold the word until it is accepted
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (emission_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_valid         <= 1'b1;
        in_source_x      <= emission_q[0].src_x;
        in_source_y      <= emission_q[0].src_y;
        in_rand_jitter_x <= emission_q[0].jit_x;
        in_rand_jitter_y <= emission_q[0].jit_y;
        in_rand_speed    <= emission_q[0].speed;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          // a third of bursts run back to back with no gap
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Monitor: stall the result side on its own run-length pattern and check.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_run <= 0;
    end else begin
      if (ready_run == 0) begin
        out_ready <= ~out_ready;
        ready_run <= out_ready ? $urandom_range(0, 6) : $urandom_range(0, 30);
      end else begin
        ready_run <= ready_run - 1;
      end
      if (out_valid && out_ready) begin
        if (velocity_q.size() == 0) begin
          $display("%0t: velocity word with nothing expected (x=%0d y=%0d)",
                   $time, out_velocity_x, out_velocity_y);
          fail_count++;
        end else begin
          velocity_t exp_v;
          exp_v = velocity_q.pop_front();
          if (out_velocity_x !== exp_v.vel_x) begin
            $display("%0t: velocity_x expected %0d actual %0d",
                     $time, exp_v.vel_x, out_velocity_x);
            fail_count++;
          end
          if (out_velocity_y !== exp_v.vel_y) begin
            $display("%0t: velocity_y expected %0d actual %0d",
                     $time, exp_v.vel_y, out_velocity_y);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [CW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      jtv_pkg::CFG_TARGET_X:         tgt_x      = data;
      jtv_pkg::CFG_TARGET_Y:         tgt_y      = data;
      jtv_pkg::CFG_TARGET_SPREAD:    tgt_spread = data[CW-2:0];
      jtv_pkg::CFG_BASE_MAGNITUDE:   base_mag   = data;
      jtv_pkg::CFG_MAGNITUDE_SPREAD: mag_spread = data[CW-2:0];
      jtv_pkg::CFG_PROPORTIONAL:     prop_mode  = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_config(input logic [CW-1:0] tx, ty, ts, bm, ms, pm);
    write_reg(jtv_pkg::CFG_TARGET_X, tx);
    write_reg(jtv_pkg::CFG_TARGET_Y, ty);
    write_reg(jtv_pkg::CFG_TARGET_SPREAD, ts);
    write_reg(jtv_pkg::CFG_BASE_MAGNITUDE, bm);
    write_reg(jtv_pkg::CFG_MAGNITUDE_SPREAD, ms);
    write_reg(jtv_pkg::CFG_PROPORTIONAL, pm);
  endtask

  task automatic queue_word(input logic [CW-1:0] sx, sy, input logic [RB-1:0] jx, jy, sp);
    emission_t e;
    e.src_x = sx;
    e.src_y = sy;
    e.jit_x = jx;
    e.jit_y = jy;
    e.speed = sp;
    @(negedge clk);
    emission_q.push_back(e);
  endtask

  // Wait until every queued word is sent and checked, then let the pipeline settle.
  task automatic drain();
    while (emission_q.size() != 0 || in_valid || velocity_q.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord(input int span_bits);
    logic [CW-1:0] r;
    r = CW'($urandom);
    if (span_bits >= CW) return r;
    return CW'($signed(r[CW-1:0]) >>> (CW - span_bits));
  endfunction

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    tgt_x = '0; tgt_y = '0; tgt_spread = '0;
    base_mag = '0; mag_spread = '0; prop_mode = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: plain speed toward a fixed target, no jitter.
    load_config(24'sd2560, -24'sd1280, 24'd0, 24'sd25600, 24'd0, 24'd0);
    queue_word(24'sd2560, -24'sd1280, 16'h0000, 16'h0000, 16'h0000);  // zero offset
    queue_word(24'sd2660, -24'sd1280, 16'h0000, 16'h0000, 16'h0000);  // straight behind
    queue_word(24'sd0, 24'sd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_word(24'sh7FFFFF, 24'sh7FFFFF, 16'h0000, 16'hFFFF, 16'h8000);
    queue_word(24'sh800000, 24'sh800000, 16'hFFFF, 16'h0000, 16'h0001);
    queue_word(24'sh800000, 24'sh7FFFFF, 16'h1234, 16'hABCD, 16'h5555);
    queue_word(24'sd2560, -24'sd1281, 16'h0000, 16'h0000, 16'h0000);
    drain();

    // Directed: proportional mode, extreme registers, masked bits, bad indexes.
    load_config(24'sh7FFFFF, 24'sh800000, 24'hFFFFFF, 24'sh7FFFFF, 24'hFFFFFF, 24'hFFFFFF);
    write_reg(3'd6, 24'hABCDEF);
    write_reg(3'd7, 24'h123456);
    queue_word(24'sh800000, 24'sh7FFFFF, 16'hFFFF, 16'h0000, 16'hFFFF);
    queue_word(24'sh7FFFFF, 24'sh800000, 16'h8000, 16'h8000, 16'h0000);
    queue_word(24'sd0, 24'sd0, 16'h0000, 16'hFFFF, 16'h7FFF);
    drain();
    load_config(24'sd100, 24'sd100, 24'd0, 24'sh800000, 24'd0, 24'd1);
    queue_word(24'sd100, 24'sd100, 16'h0000, 16'h0000, 16'h0000);    // zero offset, prop
    queue_word(24'sd300, 24'sd100, 16'hFFFF, 16'hFFFF, 16'hFFFF);    // straight behind
    queue_word(-24'sd5000, 24'sd7000, 16'h0F0F, 16'hF0F0, 16'h0000);
    queue_word(24'sh7FFFFF, 24'sh800000, 16'h0000, 16'h0000, 16'hFFFF);
    drain();

    // Random phases: fresh register values each phase, mostly modest sizes.
    for (int phase = 0; phase < 10; phase++) begin
      logic [CW-1:0] spread_t, spread_m, mag_v;
      int            span;
      span     = $urandom_range(0, 3) == 0 ? CW : $urandom_range(8, 20);
      spread_t = $urandom_range(0, 1) ? 24'($urandom_range(0, 4096)) : 24'($urandom);
      spread_m = $urandom_range(0, 1) ? 24'($urandom_range(0, 2048)) : 24'($urandom);
      mag_v    = (phase % 2) ? rand_coord(14) : rand_coord($urandom_range(10, CW));
      load_config(rand_coord(span), rand_coord(span), spread_t, mag_v, spread_m,
                  24'(phase % 2));
      for (int n = 0; n < 110; n++) begin
        logic [CW-1:0] sx, sy;
        if ($urandom_range(0, 9) == 0) begin
          // land exactly on the target when jitter is centered
          sx = tgt_x;
          sy = tgt_y;
        end else begin
          sx = rand_coord(span);
          sy = rand_coord(span);
        end
        queue_word(sx, sy, 16'($urandom), 16'($urandom), 16'($urandom));
      end
      drain();
    end

    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
